@@ rtl/core/ght_pkg.sv @@
// Shared constants, codes and types of the generational handle table.
`timescale 1ns / 1ps

package ght_pkg;

   localparam int SLOT_COUNT  = 64;
   localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int LANES       = 8;
   localparam int LANE_W      = 3;
   localparam int GROUP_COUNT = (SLOT_COUNT + LANES - 1) / LANES;
   localparam int GRP_W       = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

   localparam int TAG_W    = 32;
   localparam int HANDLE_W = 32;
   localparam int GEN_W    = 8;
   localparam int TYPE_W   = 3;
   localparam int ID_W     = 21;
   localparam int GEN_LSB  = 24;
   localparam int TYPE_LSB = 21;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_LOOKUP = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_INVALID    = 3'd1,
      ST_FULL       = 3'd2,
      ST_WRONG_TYPE = 3'd3,
      ST_NOT_OWNED  = 3'd4
   } status_type;

   typedef struct packed {
      logic              found;
      logic              last;
      logic [SLOT_W-1:0] slot;
   } scan_result_type;

endpackage

@@ rtl/core/ght_free_scan.sv @@
// Free-slot scanner: checks one group of eight used flags per cycle.
`timescale 1ns / 1ps

module ght_free_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         advance,
   input  logic [ght_pkg::SLOT_COUNT-1:0] used,
   output ght_pkg::scan_result_type     result
);
   import ght_pkg::*;

   localparam int PAD_W  = GROUP_COUNT * LANES;
   localparam int FULL_W = GRP_W + LANE_W;

   logic [GRP_W-1:0]  grp_ff;
   logic [GRP_W-1:0]  grp_in;
   logic [PAD_W-1:0]  used_pad;
   logic [LANES-1:0]  group_bits;
   logic [LANE_W-1:0] lane;
   logic              any_free;
   logic [FULL_W-1:0] full_idx;

   // slots past the end of the table read as used
   always_comb begin
      used_pad = '1;
      used_pad[SLOT_COUNT-1:0] = used;
   end

   assign group_bits = used_pad[grp_ff * LANES +: LANES];

   // lowest free lane in the group
   always_comb begin
      lane     = '0;
      any_free = 1'b0;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (!group_bits[i]) begin
            lane     = LANE_W'(i);
            any_free = 1'b1;
         end
      end
   end

   assign full_idx     = {grp_ff, lane};
   assign result.found = any_free;
   assign result.last  = (grp_ff == GRP_W'(GROUP_COUNT - 1));
   assign result.slot  = full_idx[SLOT_W-1:0];

   always_comb begin
      grp_in = grp_ff;
      if (clear) begin
         grp_in = '0;
      end else if (advance) begin
         grp_in = grp_ff + GRP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff <= '0;
      end else begin
         grp_ff <= grp_in;
      end
   end

endmodule

@@ rtl/core/ght_slot_mem.sv @@
// Slot tag and generation memories with registered reads.
`timescale 1ns / 1ps

module ght_slot_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ght_pkg::SLOT_W-1:0]    rd_addr,
   input  logic [ght_pkg::SLOT_W-1:0]    wr_addr,
   input  logic                          tag_we,
   input  logic [ght_pkg::TAG_W-1:0]     tag_wdata,
   input  logic                          gen_we,
   input  logic [ght_pkg::GEN_W-1:0]     gen_wdata,
   output logic [ght_pkg::TAG_W-1:0]     tag_rdata,
   output logic [ght_pkg::GEN_W-1:0]     gen_rdata
);
   import ght_pkg::*;

   logic [TAG_W-1:0]      tag_mem [SLOT_COUNT];
   logic [GEN_W-1:0]      gen_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] gen_valid_ff;
   logic [SLOT_COUNT-1:0] gen_valid_in;
   logic [TAG_W-1:0]      tag_rd_ff;
   logic [GEN_W-1:0]      gen_rd_ff;
   logic                  gen_ok_ff;

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[wr_addr] <= tag_wdata;
      end
      tag_rd_ff <= tag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (gen_we) begin
         gen_mem[wr_addr] <= gen_wdata;
      end
      gen_rd_ff <= gen_mem[rd_addr];
   end

   // generation never written reads as zero
   always_comb begin
      gen_valid_in = gen_valid_ff;
      if (gen_we) begin
         gen_valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_valid_ff <= '0;
         gen_ok_ff    <= 1'b0;
      end else begin
         gen_valid_ff <= gen_valid_in;
         gen_ok_ff    <= gen_valid_ff[rd_addr];
      end
   end

   assign tag_rdata = tag_rd_ff;
   assign gen_rdata = gen_ok_ff ? gen_rd_ff : '0;

endmodule

@@ rtl/core/generational_handle_table_unit.sv @@
// Top level of the generational handle table: sequencer, used flags, response.
//
//   channel  ports                      handshake
//   -------  -------------------------  -----------------------------------
//   request  req_*                      start high while busy low
//   result   rsp_*                      rsp_valid for one cycle, no stall
//   config   csr_store_type             csr_valid with csr_ready (always 1)
//
// Remove and lookup: accept issues the slot read, the next cycle checks
// the read data and answers. Add scans the used flags eight slots per
// cycle until a group has a free slot or the last group is full.
// Early rejects (bad type, bad id, unused action) answer from the idle state.
// Reset is synchronous and empties the table; no clearing pass is needed.
// The result is shown for one cycle after the item ends; the next item may
// be accepted in that same cycle.
`timescale 1ns / 1ps

module generational_handle_table_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_action,
   input  logic [ght_pkg::HANDLE_W-1:0]  req_handle_in,
   input  logic [5:0]                    req_slot_index,
   input  logic [ght_pkg::TAG_W-1:0]     req_object_tag,
   input  logic [ght_pkg::TYPE_W-1:0]    req_object_type,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [ght_pkg::HANDLE_W-1:0]  rsp_handle_out,
   output logic [ght_pkg::TAG_W-1:0]     rsp_found_tag,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ght_pkg::TYPE_W-1:0]    csr_store_type
);
   import ght_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_CHECK = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [TYPE_W-1:0]     store_type_ff;
   logic [SLOT_COUNT-1:0] used_ff, used_in;
   action_type            act_ff, act_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic [TAG_W-1:0]      tag_ff, tag_in;
   logic [GEN_W-1:0]      gen_ff, gen_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [TAG_W-1:0]      rsp_tag_ff, rsp_tag_in;

   scan_result_type       scan;
   logic                  scan_clear, scan_advance;

   logic [SLOT_W-1:0]     rd_addr;
   logic                  tag_we, gen_we;
   logic [TAG_W-1:0]      tag_rdata;
   logic [GEN_W-1:0]      gen_rdata;

   action_type            req_act;
   logic [ID_W-1:0]       req_id;
   logic [TYPE_W-1:0]     req_ty;
   logic [ID_W-1:0]       req_id_m1;
   logic [ID_W-1:0]       new_id;
   logic                  slot_used;

   ght_free_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .clear   (scan_clear),
      .advance (scan_advance),
      .used    (used_ff),
      .result  (scan)
   );

   ght_slot_mem u_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (rd_addr),
      .wr_addr   (idx_ff),
      .tag_we    (tag_we),
      .tag_wdata (tag_ff),
      .gen_we    (gen_we),
      .gen_wdata (gen_rdata + GEN_W'(1)),
      .tag_rdata (tag_rdata),
      .gen_rdata (gen_rdata)
   );

   assign req_act   = action_type'(req_action);
   assign req_id    = req_handle_in[ID_W-1:0];
   assign req_ty    = req_handle_in[TYPE_LSB +: TYPE_W];
   assign req_id_m1 = req_id - ID_W'(1);
   assign new_id    = {{(ID_W - SLOT_W){1'b0}}, idx_ff} + ID_W'(1);
   assign slot_used = used_ff[idx_ff];

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      act_in        = act_ff;
      idx_in        = idx_ff;
      tag_in        = tag_ff;
      gen_in        = gen_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_handle_in = '0;
      rsp_tag_in    = '0;
      scan_clear    = 1'b0;
      scan_advance  = 1'b0;
      rd_addr       = idx_ff;
      tag_we        = 1'b0;
      gen_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in = req_act;
               tag_in = req_object_tag;
               gen_in = req_handle_in[GEN_LSB +: GEN_W];
               case (req_act)
                  ACT_ADD: begin
                     scan_clear = 1'b1;
                     state_in   = S_SCAN;
                  end
                  ACT_REMOVE: begin
                     rd_addr = req_slot_index[SLOT_W-1:0];
                     idx_in  = req_slot_index[SLOT_W-1:0];
                     if (req_object_type != store_type_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_WRONG_TYPE;
                     end else if (32'(req_slot_index) >= SLOT_COUNT) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOT_OWNED;
                     end else begin
                        state_in = S_CHECK;
                     end
                  end
                  ACT_LOOKUP: begin
                     rd_addr = req_id_m1[SLOT_W-1:0];
                     idx_in  = req_id_m1[SLOT_W-1:0];
                     if (req_id == '0 || req_ty != store_type_ff ||
                         32'(req_id) > SLOT_COUNT) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_INVALID;
                     end else begin
                        state_in = S_CHECK;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_INVALID;
                  end
               endcase
            end
         end

         S_SCAN: begin
            rd_addr = scan.slot;
            if (scan.found) begin
               idx_in   = scan.slot;
               state_in = S_CHECK;
            end else if (scan.last) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FULL;
               state_in      = S_IDLE;
            end else begin
               scan_advance = 1'b1;
            end
         end

         S_CHECK: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            case (act_ff)
               ACT_ADD: begin
                  tag_we          = 1'b1;
                  used_in[idx_ff] = 1'b1;
                  rsp_handle_in   = {gen_rdata, store_type_ff, new_id};
               end
               ACT_REMOVE: begin
                  if (slot_used && tag_rdata == tag_ff) begin
                     gen_we          = 1'b1;
                     used_in[idx_ff] = 1'b0;
                  end else begin
                     rsp_status_in = ST_NOT_OWNED;
                  end
               end
               ACT_LOOKUP: begin
                  if (slot_used && gen_rdata == gen_ff) begin
                     rsp_tag_in = tag_rdata;
                  end else begin
                     rsp_status_in = ST_INVALID;
                  end
               end
               default: begin
                  rsp_status_in = ST_INVALID;
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         store_type_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         act_ff        <= ACT_NONE;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         act_ff       <= act_in;
         if (csr_valid && csr_ready) begin
            store_type_ff <= csr_store_type;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      tag_ff        <= tag_in;
      gen_ff        <= gen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_tag_ff    <= rsp_tag_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_found_tag  = rsp_tag_ff;

endmodule
